// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

    localparam int ARENA_WORDS_DEF = 4096;
    localparam int WORD_BYTES_DEF  = 4;

    localparam int REQ_W    = 16;
    localparam int ADDR_W   = 12;
    localparam int STATUS_W = 2;
    localparam int SLACK_W  = 4;
    localparam int WANT_W   = 16;

    localparam logic [SLACK_W-1:0] SLACK_RESET = 4'd2;

    localparam logic [1:0] TAG_FREE = 2'd0;
    localparam logic [1:0] TAG_USED = 2'd1;
    localparam logic [1:0] TAG_SKIP = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CORR,
        ST_P_RD,
        ST_P_CHK,
        ST_N_CHK,
        ST_SPLIT,
        ST_FMOD,
        ST_FCHK,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/ffa_ram.sv =====
module ffa_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// allocate walks the header list from the rover, merging adjacent free blocks and splitting
//   off the tail when it exceeds the slack; free reduces the address by repeated subtraction
//   of the arena size (none when the arena is 4096 words or more)
// throughput: one transaction at a time, set by the header memory walk
// reset: synchronous active-low; a clearing pass over every header follows, no input taken
module first_fit_heap_allocator_top #(
    parameter int ARENA_WORDS = ffa_pkg::ARENA_WORDS_DEF,
    parameter int WORD_BYTES  = ffa_pkg::WORD_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_bytes[15:0], block_address[27:16]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // granted_address[11:0], status[13:12]
);

    localparam int AW  = $clog2(ARENA_WORDS);
    localparam int HW  = AW + 2;
    localparam int SW  = AW + 4;
    localparam int CW  = ((AW > ffa_pkg::WANT_W) ? AW : ffa_pkg::WANT_W) + 2;
    localparam int MW  = (AW > ffa_pkg::ADDR_W) ? AW : ffa_pkg::ADDR_W;
    localparam int XW  = ffa_pkg::REQ_W + 1;
    localparam int K   = 20;
    localparam int RW  = K - 1;
    localparam int PW  = XW + RW;
    localparam logic [RW-1:0] RECIP = RW'((1 << K) / WORD_BYTES);
    localparam logic [SW-1:0] LIMIT = SW'(4 * ARENA_WORDS + 8);
    localparam logic [AW-1:0] LAST  = AW'(ARENA_WORDS - 1);

    ffa_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                  clr_reg, clr_next;
    logic [AW-1:0]                  p_reg, p_next;
    logic [AW-1:0]                  n_reg, n_next;
    logic [AW-1:0]                  start_reg, start_next;
    logic [AW-1:0]                  rover_reg, rover_next;
    logic [SW-1:0]                  steps_reg, steps_next;
    logic                           atend_reg, atend_next;
    logic [ffa_pkg::WANT_W-1:0]     want_reg, want_next;
    logic [XW-1:0]                  q_reg, q_next;
    logic [ffa_pkg::REQ_W-1:0]      bytes_reg, bytes_next;
    logic [MW-1:0]                  mod_reg, mod_next;
    logic [ffa_pkg::SLACK_W-1:0]    slack_reg;
    logic [ffa_pkg::ADDR_W-1:0]     grant_reg, grant_next;
    logic [ffa_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           m_valid_reg, m_valid_next;
    logic [15:0]                    m_data_reg, m_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [HW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [HW-1:0] ram_rdata;

    logic [1:0]    rd_tag;
    logic [AW-1:0] rd_link;
    logic [CW-1:0] span;
    logic [CW-1:0] want_ext;
    logic [SW-1:0] steps_inc;
    logic [XW-1:0] x_val;
    logic [PW-1:0] prod;
    logic [XW-1:0] rem;
    logic [AW-1:0] end_idx;
    logic [31:0]   grant32;

    ffa_ram #(
        .WIDTH(HW),
        .DEPTH(ARENA_WORDS)
    ) u_hdr_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_tready = (state_reg == ffa_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign rd_tag    = ram_rdata[1:0];
    assign rd_link   = ram_rdata[HW-1:2];
    assign span      = (n_reg > p_reg) ? (CW'(n_reg) - CW'(p_reg) - CW'(1)) : CW'(0);
    assign want_ext  = CW'(want_reg);
    assign steps_inc = steps_reg + SW'(1);
    assign x_val     = XW'(bytes_reg) + XW'(WORD_BYTES - 1);
    assign prod      = PW'(x_val) * PW'(RECIP);
    assign rem       = x_val - XW'(q_reg * XW'(WORD_BYTES));
    assign end_idx   = p_reg + AW'(1) + AW'(want_reg);
    assign grant32   = 32'(p_reg) + 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffa_pkg::ST_CLEAR;
            clr_reg     <= '0;
            rover_reg   <= '0;
            slack_reg   <= ffa_pkg::SLACK_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rover_reg   <= rover_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                slack_reg <= cfg_wdata;
            end
        end
        p_reg      <= p_next;
        n_reg      <= n_next;
        start_reg  <= start_next;
        steps_reg  <= steps_next;
        atend_reg  <= atend_next;
        want_reg   <= want_next;
        q_reg      <= q_next;
        bytes_reg  <= bytes_next;
        mod_reg    <= mod_next;
        grant_reg  <= grant_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        start_next   = start_reg;
        rover_next   = rover_reg;
        steps_next   = steps_reg;
        atend_next   = atend_reg;
        want_next    = want_reg;
        q_next       = q_reg;
        bytes_next   = bytes_reg;
        mod_next     = mod_reg;
        grant_next   = grant_reg;
        status_next  = status_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ram_we       = 1'b0;
        ram_waddr    = p_reg;
        ram_wdata    = '0;
        ram_raddr    = p_reg;

        case (state_reg)
            ffa_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == '0) begin
                    ram_wdata = {LAST, ffa_pkg::TAG_FREE};
                end else if (clr_reg == LAST) begin
                    ram_wdata = {AW'(0), ffa_pkg::TAG_SKIP};
                end
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST) begin
                    state_next = ffa_pkg::ST_IDLE;
                end
            end
            ffa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    bytes_next = s_tdata[15:0];
                    mod_next   = MW'(s_tdata[27:16]);
                    grant_next = '0;
                    if (s_tuser == ffa_pkg::OP_FREE) begin
                        state_next = ffa_pkg::ST_FMOD;
                    end else begin
                        state_next = ffa_pkg::ST_DIV;
                    end
                end
            end
            ffa_pkg::ST_DIV: begin
                q_next     = XW'(prod[PW-1:K]);
                state_next = ffa_pkg::ST_CORR;
            end
            ffa_pkg::ST_CORR: begin
                if (bytes_reg == '0) begin
                    want_next = ffa_pkg::WANT_W'(1);
                end else if (rem >= XW'(WORD_BYTES)) begin
                    want_next = ffa_pkg::WANT_W'(q_reg + XW'(1));
                end else begin
                    want_next = ffa_pkg::WANT_W'(q_reg);
                end
                start_next = rover_reg;
                p_next     = rover_reg;
                steps_next = '0;
                atend_next = 1'b0;
                state_next = ffa_pkg::ST_P_RD;
            end
            ffa_pkg::ST_P_RD: begin
                if (steps_inc > LIMIT || atend_reg) begin
                    status_next = ffa_pkg::STATUS_NO_SPACE;
                    grant_next  = '0;
                    state_next  = ffa_pkg::ST_OUT;
                end else begin
                    steps_next = steps_inc;
                    ram_raddr  = p_reg;
                    state_next = ffa_pkg::ST_P_CHK;
                end
            end
            ffa_pkg::ST_P_CHK: begin
                if (rd_tag != ffa_pkg::TAG_FREE) begin
                    p_next     = rd_link;
                    atend_next = (rd_link == start_reg);
                    state_next = ffa_pkg::ST_P_RD;
                end else begin
                    n_next     = rd_link;
                    ram_raddr  = rd_link;
                    state_next = ffa_pkg::ST_N_CHK;
                end
            end
            ffa_pkg::ST_N_CHK: begin
                if (rd_tag != ffa_pkg::TAG_FREE || span >= want_ext || n_reg == p_reg
                        || steps_inc > LIMIT) begin
                    if (!(rd_tag != ffa_pkg::TAG_FREE || span >= want_ext
                            || n_reg == p_reg)) begin
                        steps_next = steps_inc;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = p_reg;
                    if (span < want_ext) begin
                        ram_wdata  = {n_reg, ffa_pkg::TAG_FREE};
                        p_next     = n_reg;
                        atend_next = (n_reg == start_reg);
                        state_next = ffa_pkg::ST_P_RD;
                    end else if (want_ext + CW'(slack_reg) >= span) begin
                        ram_wdata   = {n_reg, ffa_pkg::TAG_USED};
                        rover_next  = p_reg;
                        grant_next  = grant32[ffa_pkg::ADDR_W-1:0];
                        status_next = ffa_pkg::STATUS_DONE;
                        state_next  = ffa_pkg::ST_OUT;
                    end else begin
                        ram_waddr  = end_idx;
                        ram_wdata  = {n_reg, ffa_pkg::TAG_FREE};
                        state_next = ffa_pkg::ST_SPLIT;
                    end
                end else begin
                    steps_next = steps_inc;
                    if (n_reg == start_reg) begin
                        start_next = rd_link;
                        rover_next = rd_link;
                    end
                    n_next    = rd_link;
                    ram_raddr = rd_link;
                end
            end
            ffa_pkg::ST_SPLIT: begin
                ram_we      = 1'b1;
                ram_waddr   = p_reg;
                ram_wdata   = {end_idx, ffa_pkg::TAG_USED};
                rover_next  = p_reg;
                grant_next  = grant32[ffa_pkg::ADDR_W-1:0];
                status_next = ffa_pkg::STATUS_DONE;
                state_next  = ffa_pkg::ST_OUT;
            end
            ffa_pkg::ST_FMOD: begin
                if ((MW + 1)'(mod_reg) >= (MW + 1)'(ARENA_WORDS)) begin
                    mod_next = mod_reg - MW'(ARENA_WORDS);
                end else begin
                    if (mod_reg == '0) begin
                        p_next = LAST;
                    end else begin
                        p_next = AW'(mod_reg - MW'(1));
                    end
                    ram_raddr  = p_next;
                    state_next = ffa_pkg::ST_FCHK;
                end
            end
            ffa_pkg::ST_FCHK: begin
                grant_next = '0;
                if (rd_tag == ffa_pkg::TAG_USED) begin
                    ram_we      = 1'b1;
                    ram_waddr   = p_reg;
                    ram_wdata   = {rd_link, ffa_pkg::TAG_FREE};
                    status_next = ffa_pkg::STATUS_DONE;
                end else begin
                    status_next = ffa_pkg::STATUS_NOT_USED;
                end
                state_next = ffa_pkg::ST_OUT;
            end
            ffa_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, status_reg, grant_reg};
                    state_next   = ffa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sim/first_fit_heap_allocator_top_tb.sv =====
module first_fit_heap_allocator_top_tb;

    localparam int ARENA     = ffa_pkg::ARENA_WORDS_DEF;
    localparam int WBYTES    = ffa_pkg::WORD_BYTES_DEF;
    localparam int N_RANDOM  = 930;
    localparam longint LIMIT = 64'd200000000;

    typedef struct packed {
        logic [ffa_pkg::ADDR_W-1:0]   grant;
        logic [ffa_pkg::STATUS_W-1:0] status;
    } alloc_result_t;

    class heap_scoreboard;
        logic [13:0]                  hdr [ARENA];
        logic [ffa_pkg::ADDR_W-1:0]   rover;
        logic [ffa_pkg::SLACK_W-1:0]  slack;
        alloc_result_t                pending [$];
        logic [ffa_pkg::ADDR_W-1:0]   live [$];
        int                           errors;
        int                           n_granted, n_no_space, n_freed, n_bad_free, n_checked;

        function void reset_state();
            foreach (hdr[i]) hdr[i] = '0;
            hdr[0]       = {12'(ARENA - 1), ffa_pkg::TAG_FREE};
            hdr[ARENA-1] = {12'd0, ffa_pkg::TAG_SKIP};
            rover = '0;
            slack = ffa_pkg::SLACK_RESET;
        endfunction

        function int span(int p, int n);
            return (n > p) ? n - p - 1 : 0;
        endfunction

        function logic [ffa_pkg::STATUS_W-1:0] search(int want,
                                                      output logic [ffa_pkg::ADDR_W-1:0] g);
            int limit, steps, start, p, n, size, tail;
            bit atend;
            limit = 4 * ARENA + 8;
            steps = 0;
            start = rover;
            p = start;
            atend = 0;
            g = '0;
            forever begin
                steps++;
                if (steps > limit || atend)
                    return ffa_pkg::STATUS_NO_SPACE;
                if (hdr[p][1:0] != ffa_pkg::TAG_FREE) begin
                    p = hdr[p][13:2];
                    if (p == start) atend = 1;
                    continue;
                end
                n = hdr[p][13:2];
                forever begin
                    if (hdr[n][1:0] != ffa_pkg::TAG_FREE) break;
                    if (span(p, n) >= want) break;
                    if (n == p) break;
                    steps++;
                    if (steps > limit) break;
                    if (n == start) begin
                        start = hdr[n][13:2];
                        rover = 12'(start);
                    end
                    n = hdr[n][13:2];
                end
                hdr[p] = {12'(n), ffa_pkg::TAG_FREE};
                size = span(p, n);
                if (size < want) begin
                    p = n;
                    if (p == start) atend = 1;
                    continue;
                end
                if (want + int'(slack) >= size) begin
                    hdr[p] = {12'(n), ffa_pkg::TAG_USED};
                end else begin
                    tail = p + 1 + want;
                    hdr[tail] = {12'(n), ffa_pkg::TAG_FREE};
                    hdr[p]    = {12'(tail), ffa_pkg::TAG_USED};
                end
                rover = 12'(p);
                g = 12'(p + 1);
                return ffa_pkg::STATUS_DONE;
            end
        endfunction

        function void note_request(logic op, logic [ffa_pkg::REQ_W-1:0] bytes,
                                   logic [ffa_pkg::ADDR_W-1:0] addr);
            alloc_result_t r;
            int want;
            logic [ffa_pkg::ADDR_W-1:0] h;
            r = '0;
            if (op == ffa_pkg::OP_ALLOC) begin
                want = (bytes == 0) ? 1 : (int'(bytes) + WBYTES - 1) / WBYTES;
                r.status = search(want, r.grant);
                if (r.status == ffa_pkg::STATUS_DONE) begin
                    live.push_back(r.grant);
                    n_granted++;
                end else begin
                    r.grant = '0;
                    n_no_space++;
                end
            end else begin
                h = addr - 1'b1;
                if (hdr[h][1:0] != ffa_pkg::TAG_USED) begin
                    r.status = ffa_pkg::STATUS_NOT_USED;
                    n_bad_free++;
                end else begin
                    hdr[h][1:0] = ffa_pkg::TAG_FREE;
                    r.status = ffa_pkg::STATUS_DONE;
                    n_freed++;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] data);
            alloc_result_t e;
            n_checked++;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[11:0] !== e.grant) begin
                $error("granted_address expected %0d actual %0d", e.grant, data[11:0]);
                errors++;
            end
            if (data[13:12] !== e.status) begin
                $error("status expected %0d actual %0d", e.status, data[13:12]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;

    heap_scoreboard sb;
    longint cycles = 0;
    bit     no_gaps = 0;
    bit     hold_req = 0;

    first_fit_heap_allocator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("first_fit_heap_allocator_top_tb failed");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // result side: random stalls plus one long hold-off
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                repeat (400) begin
                    @(negedge aclk);
                    m_tready <= 0;
                end
                hold_req = 0;
            end
            g = no_gaps ? 0 : $urandom_range(0, 11);
            repeat (g) begin
                @(negedge aclk);
                m_tready <= 0;
            end
            @(negedge aclk);
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send(logic op, logic [ffa_pkg::REQ_W-1:0] bytes,
                        logic [ffa_pkg::ADDR_W-1:0] addr);
        int g;
        g = no_gaps ? 0 : $urandom_range(0, 11);
        repeat (g) begin
            @(negedge aclk);
            s_tvalid <= 0;
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, addr, bytes};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, bytes, addr);
    endtask

    task automatic drain_and_config(logic [3:0] v);
        @(negedge aclk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 0;
        sb.slack = v;
    endtask

    task automatic random_op();
        int k, r;
        r = $urandom_range(0, 99);
        if (sb.live.size() > 120) r = r + 40;
        if (r < 55) begin
            k = $urandom_range(0, 99);
            if (k < 75)
                send(ffa_pkg::OP_ALLOC, 16'($urandom_range(0, 200)), 12'($urandom));
            else if (k < 95)
                send(ffa_pkg::OP_ALLOC, 16'($urandom_range(200, 3000)), 12'($urandom));
            else
                send(ffa_pkg::OP_ALLOC, 16'($urandom), 12'($urandom));
        end else begin
            k = $urandom_range(0, 99);
            if (k < 80 && sb.live.size() > 0) begin
                r = $urandom_range(0, sb.live.size() - 1);
                send(ffa_pkg::OP_FREE, 16'($urandom), sb.live[r]);
                sb.live.delete(r);
            end else begin
                send(ffa_pkg::OP_FREE, 16'($urandom), 12'($urandom));
            end
        end
    endtask

    initial begin
        logic [3:0] settings [4];
        logic [ffa_pkg::ADDR_W-1:0] a;
        settings = '{4'd0, 4'd15, 4'd7, 4'd2};
        sb = new();
        sb.reset_state();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        send(ffa_pkg::OP_ALLOC, 16'd0, 12'd0);
        send(ffa_pkg::OP_ALLOC, 16'd1, 12'hfff);
        send(ffa_pkg::OP_ALLOC, 16'd4, 12'd0);
        send(ffa_pkg::OP_ALLOC, 16'd5, 12'd0);
        send(ffa_pkg::OP_ALLOC, 16'hffff, 12'd0);
        send(ffa_pkg::OP_ALLOC, 16'd16380, 12'd0);
        send(ffa_pkg::OP_FREE, 16'd0, 12'd0);
        send(ffa_pkg::OP_FREE, 16'hffff, 12'hfff);
        send(ffa_pkg::OP_FREE, 16'd0, 12'd1);
        send(ffa_pkg::OP_FREE, 16'd0, 12'd1);
        send(ffa_pkg::OP_FREE, 16'd0, 12'd2048);
        send(ffa_pkg::OP_ALLOC, 16'd12000, 12'd0);
        send(ffa_pkg::OP_ALLOC, 16'd8, 12'd0);
        a = sb.live[1];
        send(ffa_pkg::OP_FREE, 16'd0, a);
        a = sb.live[2];
        send(ffa_pkg::OP_FREE, 16'd0, a);
        send(ffa_pkg::OP_ALLOC, 16'd2, 12'd0);
        send(ffa_pkg::OP_ALLOC, 16'd4000, 12'd0);
        a = sb.live[3];
        send(ffa_pkg::OP_FREE, 16'd0, a);
        send(ffa_pkg::OP_FREE, 16'd0, a);
        sb.live.delete();
        sb.live.push_back(12'd0);
        sb.live.delete();

        for (int ph = 0; ph < 4; ph++) begin
            drain_and_config(settings[ph]);
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                if (ph == 1 && i == 40) hold_req = 1;
                if (i == 100) no_gaps = 1;
                if (i == 160) no_gaps = 0;
                random_op();
            end
        end

        @(negedge aclk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d grants, %0d out-of-space, %0d frees, %0d rejected frees",
                 sb.n_granted, sb.n_no_space, sb.n_freed, sb.n_bad_free);
        $display("slack settings 2, 0, 15, 7 and 2; %0d results checked", sb.n_checked);
        if (sb.errors == 0)
            $display("first_fit_heap_allocator_top_tb passed");
        else
            $display("first_fit_heap_allocator_top_tb failed");
        $finish;
    end
endmodule
